@@ hdl/assert_macros.svh @@
// Assertion macros for the free frame allocator RTL, used by the list engine.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Property that must hold whenever the antecedent is true.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ hdl/ffa_pkg.sv @@
// Package of the free frame allocator: sizes, codes, shared types and helpers.
// Has no dependencies; every other RTL file but ffa_ram imports it.
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int unsigned MAX_FRAMES = 64;
  localparam int unsigned PTR_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_FRAMES + 1);
  // One bit above the count so that any saturated need exceeds every count.
  localparam int unsigned NEED_W     = CNT_W + 1;

  localparam int unsigned FRAME_W    = 6;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned SIZE_W     = 23;
  localparam int unsigned FSIZE_W    = 17;
  localparam int unsigned FCOUNT_W   = 7;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [FSIZE_W-1:0]  FRAME_SIZE_RST  = 17'd1024;
  localparam logic [FCOUNT_W-1:0] FRAME_COUNT_RST = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_FREE      = 2'd0,
    CMD_TAKE      = 2'd1,
    CMD_TAKE_SIZE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FRAMES = 2'd1,
    ST_LIST_FULL = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_SIZE  = 2'd0,
    REG_FRAME_COUNT = 2'd1
  } cfg_reg_e;

  // Classified request handed from the front end to the list engine.
  // A single take is a sized take that needs exactly one frame.
  typedef struct packed {
    logic               is_free;
    logic [FRAME_W-1:0] frame;
    logic [NEED_W-1:0]  need;
  } ffa_op_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] count;
  } ffa_refill_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [FCOUNT_W-1:0] n);
    if (32'(n) > MAX_FRAMES) begin
      return CNT_W'(MAX_FRAMES);
    end
    return CNT_W'(n);
  endfunction

  function automatic logic [PTR_W-1:0] wrap_ptr(input logic [CNT_W-1:0] n);
    return (32'(n) >= MAX_FRAMES) ? '0 : PTR_W'(n);
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (32'(p) == MAX_FRAMES - 1) ? '0 : p + 1'b1;
  endfunction

endpackage

@@ hdl/ffa_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/ffa_front.sv @@
// Front end of the free frame allocator: takes requests, classifies them and
// runs the bit-serial divide for sized takes. Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_front import ffa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [CMD_W-1:0]   command_i,
  input  logic [FRAME_W-1:0] frame_number_i,
  input  logic [SIZE_W-1:0]  size_bytes_i,
  input  logic [FSIZE_W-1:0] frame_size_i,
  output logic               full_o,
  output logic               op_valid_o,
  output ffa_op_t            op_o,
  input  logic               op_ready_i
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_e;

  localparam int unsigned STEP_W   = $clog2(SIZE_W);
  localparam int unsigned NEED_MAX = (1 << NEED_W) - 1;

  fstate_e              state_q, state_d;
  ffa_op_t              op_q, op_d;
  logic [FSIZE_W-1:0]   rem_q, rem_d;
  logic [SIZE_W-1:0]    dvd_q, dvd_d;
  logic [STEP_W-1:0]    step_q, step_d;

  logic [FSIZE_W-1:0]   divisor;
  logic [FSIZE_W:0]     shifted;
  logic [FSIZE_W:0]     diff;
  logic                 fits;
  logic [SIZE_W:0]      need_sum;
  logic                 accept;

  assign full_o     = (state_q != F_IDLE);
  assign op_valid_o = (state_q == F_PUSH);
  assign op_o       = op_q;
  assign accept     = push_i && !full_o;

  // A zero frame size divides as one.
  assign divisor = (frame_size_i == '0) ? FSIZE_W'(1) : frame_size_i;
  assign shifted = {rem_q, dvd_q[SIZE_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign fits    = (shifted >= {1'b0, divisor});

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    step_d   = step_q;
    need_sum = '0;

    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          op_d.frame = frame_number_i;
          case (command_i)
            CMD_FREE: begin
              op_d.is_free = 1'b1;
              op_d.need    = '0;
              state_d      = F_PUSH;
            end
            CMD_TAKE: begin
              op_d.is_free = 1'b0;
              op_d.need    = NEED_W'(1);
              state_d      = F_PUSH;
            end
            CMD_TAKE_SIZE: begin
              op_d.is_free = 1'b0;
              op_d.need    = '0;
              if (size_bytes_i == '0) begin
                state_d = F_PUSH;
              end else begin
                rem_d   = '0;
                dvd_d   = size_bytes_i;
                step_d  = '0;
                state_d = F_DIV;
              end
            end
            default: begin
              // The unused command is dropped without a result.
              state_d = F_IDLE;
            end
          endcase
        end
      end
      F_DIV: begin
        // One quotient bit per cycle; quotient bits shift in behind the dividend.
        rem_d  = fits ? diff[FSIZE_W-1:0] : shifted[FSIZE_W-1:0];
        dvd_d  = {dvd_q[SIZE_W-2:0], fits};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SIZE_W - 1)) begin
          // Round up on a nonzero remainder, then saturate to the need width.
          need_sum = {1'b0, dvd_d} + (SIZE_W + 1)'(rem_d != '0);
          if (need_sum > (SIZE_W + 1)'(NEED_MAX)) begin
            op_d.need = NEED_W'(NEED_MAX);
          end else begin
            op_d.need = need_sum[NEED_W-1:0];
          end
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (op_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      op_q    <= '0;
      rem_q   <= '0;
      dvd_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      rem_q   <= rem_d;
      dvd_q   <= dvd_d;
      step_q  <= step_d;
    end
  end

endmodule

@@ hdl/ffa_opq.sv @@
// Two-entry queue of classified requests between front end and list engine.
// Depends on ffa_pkg.
`timescale 1ns / 1ps

module ffa_opq import ffa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  ffa_op_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    empty_o,
  output ffa_op_t data_o
);

  ffa_op_t    slot_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

@@ hdl/ffa_back.sv @@
// List engine of the free frame allocator: owns the circular free list, runs
// queued requests and holds the result register. Depends on ffa_pkg, ffa_ram.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffa_back import ffa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffa_refill_t         refill_i,
  input  logic                op_empty_i,
  input  ffa_op_t             op_i,
  output logic                op_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [STATUS_W-1:0] status_o,
  output logic                has_frame_o,
  output logic [FRAME_W-1:0]  frame_out_o,
  output logic                last_o
);

  typedef enum logic {B_IDLE, B_EMIT} bstate_e;

  localparam logic [CNT_W-1:0] COUNT_RST = clamp_count(FRAME_COUNT_RST);

  bstate_e               state_q, state_d;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [PTR_W-1:0]      tail_q, tail_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [CNT_W-1:0]      remain_q, remain_d;
  logic [MAX_FRAMES-1:0] written_q, written_d;
  logic                  hit_q;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic                  has_q, has_d;
  logic [FRAME_W-1:0]    frame_q, frame_d;
  logic                  last_q, last_d;

  logic                  out_free;
  logic                  ram_we;
  logic [FRAME_W-1:0]    ram_rdata;
  logic [PTR_W-1:0]      tail_chk;
  logic                  emit_ok;

  // The list memory is read at the next head every cycle, so the entry at the
  // head is ready by the time a take reaches the emit state.
  ffa_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (MAX_FRAMES)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (op_i.frame),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  assign out_free    = !out_valid_q || pop_i;
  assign empty_o     = !out_valid_q;
  assign status_o    = status_q;
  assign has_frame_o = has_q;
  assign frame_out_o = frame_q;
  assign last_o      = last_q;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    remain_d    = remain_q;
    written_d   = written_q;
    status_d    = status_q;
    has_d       = has_q;
    frame_d     = frame_q;
    last_d      = last_q;
    out_valid_d = pop_i ? 1'b0 : out_valid_q;
    op_pop_o    = 1'b0;
    ram_we      = 1'b0;

    unique case (state_q)
      B_IDLE: begin
        if (!op_empty_i && out_free) begin
          op_pop_o = 1'b1;
          has_d    = 1'b0;
          frame_d  = '0;
          last_d   = 1'b1;
          if (op_i.is_free) begin
            out_valid_d = 1'b1;
            if (32'(count_q) >= MAX_FRAMES) begin
              status_d = ST_LIST_FULL;
            end else begin
              status_d          = ST_OK;
              ram_we            = 1'b1;
              written_d[tail_q] = 1'b1;
              tail_d            = next_ptr(tail_q);
              count_d           = count_q + 1'b1;
            end
          end else if (op_i.need == '0) begin
            out_valid_d = 1'b1;
            status_d    = ST_OK;
          end else if (op_i.need > NEED_W'(count_q)) begin
            out_valid_d = 1'b1;
            status_d    = ST_NO_FRAMES;
          end else begin
            remain_d = CNT_W'(op_i.need);
            state_d  = B_EMIT;
          end
        end
      end
      B_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          has_d       = 1'b1;
          // An entry never written since the last refill still holds its index.
          frame_d     = hit_q ? ram_rdata : FRAME_W'(head_q);
          last_d      = (remain_q == CNT_W'(1));
          head_d      = next_ptr(head_q);
          count_d     = count_q - 1'b1;
          remain_d    = remain_q - 1'b1;
          if (remain_q == CNT_W'(1)) begin
            state_d = B_IDLE;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase

    if (refill_i.valid) begin
      head_d    = '0;
      tail_d    = wrap_ptr(refill_i.count);
      count_d   = refill_i.count;
      written_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      head_q      <= '0;
      tail_q      <= wrap_ptr(COUNT_RST);
      count_q     <= COUNT_RST;
      remain_q    <= '0;
      written_q   <= '0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= ST_OK;
      has_q       <= 1'b0;
      frame_q     <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      written_q   <= written_d;
      hit_q       <= written_q[head_d];
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      has_q       <= has_d;
      frame_q     <= frame_d;
      last_q      <= last_d;
    end
  end

  assign tail_chk = PTR_W'((32'(head_q) + 32'(count_q)) % MAX_FRAMES);
  assign emit_ok  = (remain_q != '0) && (remain_q <= count_q);

  `ASSERT_ALWAYS(a_count_range, 32'(count_q) <= MAX_FRAMES, "free count above list size")
  `ASSERT_ALWAYS(a_ring_consistent, tail_q == tail_chk, "head, tail and count disagree")
  `ASSERT_IMPL(a_emit_covered, state_q == B_EMIT, emit_ok, "take runs past the free frames")

endmodule

@@ hdl/free_frame_fifo_allocator_top.sv @@
// Top level of the free frame allocator: configuration registers and the
// front end, request queue and list engine. Depends on ffa_pkg and all ffa_ modules.
`timescale 1ns / 1ps

// The block keeps a first-in first-out list of free page frame numbers. After
// reset, or whenever frame_count is written, the list holds frames 0 up to
// frame_count-1 in order (a count of 0 empties it, counts above 64 give 64).
// Requests enter through push/full and results leave through empty/pop; every
// request except the unused command 3 yields at least one result, and the
// final result of a request has last set. A free appends frame_number at the
// tail (status 2 and the frame is dropped when the list is full). A single
// take returns the head frame or status 1 when the list is empty. A sized take
// needs ceil(size_bytes / frame_size) frames (a frame_size of 0 counts as 1):
// it returns all of them in list order or one status 1 result, and a size of
// zero gives one ok result without a frame. A sized take first passes the
// bit-serial divider of the front end and is then emitted by the list engine
// at one frame per cycle while pop keeps up. The front end is free again
// once the request has entered the two-entry queue, so a following request
// overlaps with the emission of the previous one. The free list lives in a
// 64 x 6 RAM with registered read; one valid bit per entry, cleared by reset
// and by a frame_count write, makes never-written entries read as their own
// index, so no clearing pass is needed and requests are taken right after
// reset. Configuration writes are always accepted and should only be issued
// while no request is outstanding.
module free_frame_fifo_allocator_top import ffa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [FRAME_W-1:0]    frame_number_i,
  input  logic [SIZE_W-1:0]     size_bytes_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  has_frame_o,
  output logic [FRAME_W-1:0]    frame_out_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [FSIZE_W-1:0] frame_size_q, frame_size_d;
  ffa_refill_t        refill;
  logic               cfg_write;

  logic               op_valid;
  ffa_op_t            op_front;
  logic               opq_full;
  logic               opq_empty;
  ffa_op_t            op_back;
  logic               op_pop;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  // Register decode. A frame_count write refills the list in the same cycle;
  // writes to unknown indexes are ignored.
  always_comb begin
    frame_size_d = frame_size_q;
    refill       = '0;
    if (cfg_write) begin
      unique case (cfg_index_i)
        REG_FRAME_SIZE: begin
          frame_size_d = cfg_data_i[FSIZE_W-1:0];
        end
        REG_FRAME_COUNT: begin
          refill.valid = 1'b1;
          refill.count = clamp_count(cfg_data_i[FCOUNT_W-1:0]);
        end
        default: begin
          frame_size_d = frame_size_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_size_q <= FRAME_SIZE_RST;
    end else begin
      frame_size_q <= frame_size_d;
    end
  end

  // Front end: accepts requests and turns sized takes into a frame count.
  ffa_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .command_i      (command_i),
    .frame_number_i (frame_number_i),
    .size_bytes_i   (size_bytes_i),
    .frame_size_i   (frame_size_q),
    .full_o         (full),
    .op_valid_o     (op_valid),
    .op_o           (op_front),
    .op_ready_i     (!opq_full)
  );

  // Short request queue that decouples the divider from the list engine.
  ffa_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (op_valid),
    .data_i  (op_front),
    .full_o  (opq_full),
    .pop_i   (op_pop),
    .empty_o (opq_empty),
    .data_o  (op_back)
  );

  // List engine: owns the free list and the result register.
  ffa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .refill_i    (refill),
    .op_empty_i  (opq_empty),
    .op_i        (op_back),
    .op_pop_o    (op_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .status_o    (status_o),
    .has_frame_o (has_frame_o),
    .frame_out_o (frame_out_o),
    .last_o      (last_o)
  );

endmodule
